[rtl/bilinear_image_scaler_top_defines.svh]
// Assertion macros for the bilinear image scaler.
`ifndef BILINEAR_IMAGE_SCALER_TOP_DEFINES_SVH
`define BILINEAR_IMAGE_SCALER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define BIS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bilinear scaler check failed");
// Next-cycle implication, disabled during reset.
`define BIS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bilinear scaler check failed");
`else
`define BIS_ASSERT_IMP(lbl, ante, cons)
`define BIS_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

[rtl/bis_pkg.sv]
// Shared types and constants of the bilinear image scaler.
`default_nettype none
package bis_pkg;
  localparam int CFG_DATA_W  = 28;
  localparam int CFG_INDEX_W = 2;
  localparam int SRC_ADDR_W  = 18;
  localparam int FULL_ADDR_W = 42;
  localparam int WGT_W       = 33;
  localparam int ACC_W       = 40;

  localparam logic [16:0] ONE_Q16        = 17'h10000;
  localparam logic [2:0]  READ_STEPS     = 3'd4;
  localparam logic [2:0]  CHAN_LAST_STEP = 3'd5;

  typedef enum logic [1:0] {
    REG_SOURCE_WIDTH = 2'd0,
    REG_CHANNELS     = 2'd1,
    REG_RATIO_X      = 2'd2,
    REG_RATIO_Y      = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    REQ_LOAD    = 1'b0,
    REQ_COMPUTE = 1'b1
  } req_kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_POS,
    ST_MUL_WGT,
    ST_BASE,
    ST_CHAN,
    ST_EMIT
  } seq_state_t;

  typedef struct packed {
    logic                  en;
    logic [SRC_ADDR_W-1:0] addr;
    logic [7:0]            data;
  } fs_wr_t;

  typedef struct packed {
    logic                   en;
    logic [FULL_ADDR_W-1:0] addr;
  } fs_rd_t;
endpackage
`default_nettype wire

[rtl/bis_frame_store.sv]
// Source frame store: one write port, one registered read port, range masking.
`default_nettype none
module bis_frame_store #(
  parameter int SOURCE_BYTES = 262144
) (
  input  wire logic           clk,
  input  wire bis_pkg::fs_wr_t wr,
  input  wire bis_pkg::fs_rd_t rd,
  output logic [7:0]          rd_byte
);
  localparam int AW  = $clog2(SOURCE_BYTES);
  localparam int FAW = bis_pkg::FULL_ADDR_W;
  localparam logic [FAW-1:0] LIMIT = FAW'(SOURCE_BYTES);

  logic [7:0]    mem [SOURCE_BYTES];
  logic [7:0]    mem_q;
  logic          oob_q;
  logic [AW-1:0] wr_idx;
  logic [AW-1:0] rd_idx;
  logic          wr_hit;
  logic          rd_hit;

  assign wr_idx = AW'(wr.addr);
  assign rd_idx = AW'(rd.addr);
  assign wr_hit = wr.en && (FAW'(wr.addr) < LIMIT);
  assign rd_hit = rd.addr < LIMIT;

  // Drop writes beyond the store; corners beyond it read as zero.
  always_ff @(posedge clk) begin
    if (wr_hit) begin
      mem[wr_idx] <= wr.data;
    end
    if (rd.en) begin
      mem_q <= mem[rd_idx];
      oob_q <= !rd_hit;
    end
  end

  assign rd_byte = oob_q ? 8'd0 : mem_q;
endmodule
`default_nettype wire

[rtl/bilinear_image_scaler_top.sv]
// Top level of the bilinear image scaler: sequencer, arithmetic and output stage.
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+-------------------------------------------
//  in       | in        | in_valid / in_ready  | req_type, source_address, source_value,
//           |           |                      | dest_x, dest_y
//  out      | out       | out_valid / out_ready| pixel_byte, channel_index, last_channel
//  cfg      | in        | cfg_write            | cfg_index, cfg_data
//
// A load beat writes the frame store directly from idle.
// A compute beat runs the setup states MUL_POS, MUL_WGT and BASE, then for each channel
// the CHAN state, with its four corner reads through the single store read port, and EMIT.
// Reset clears the sequencer and output valid and sets the config registers to their
// defaults; the frame store keeps its contents and is not swept.
// The sequencer holds in its emit step while the output register is full and not
// taken; the input side reopens as soon as the last channel is in the output register.
`default_nettype none
`include "bilinear_image_scaler_top_defines.svh"
module bilinear_image_scaler_top #(
  parameter int SOURCE_BYTES = 262144,
  parameter int MAX_CHANNELS = 4,
  parameter int COORD_BITS   = 12
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic                               req_type,
  input  wire logic [17:0]                        source_address,
  input  wire logic [7:0]                         source_value,
  input  wire logic [11:0]                        dest_x,
  input  wire logic [11:0]                        dest_y,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic [7:0]                              pixel_byte,
  output logic [1:0]                              channel_index,
  output logic                                    last_channel,
  input  wire logic                               cfg_write,
  input  wire logic [bis_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [bis_pkg::CFG_DATA_W-1:0]     cfg_data
);
  // Coordinates are masked to COORD_BITS; the port carries at most 12.
  localparam int CW  = (COORD_BITS < 12) ? COORD_BITS : 12;
  localparam int PW  = CW + 28;   // position in Q24.16 (CW + 12 integer bits)
  localparam int IW  = PW - 16;   // integer part of the position
  localparam int XOW = IW + 3;    // x1 * channels
  localparam int YOW = IW + 16;   // y1 * stride
  localparam int FAW = bis_pkg::FULL_ADDR_W;
  localparam int WW  = bis_pkg::WGT_W;
  localparam int AW  = bis_pkg::ACC_W;

  // Configuration registers
  logic [12:0] source_width;
  logic [2:0]  channels;
  logic [27:0] ratio_x_q16;
  logic [27:0] ratio_y_q16;
  logic [2:0]  ch_eff;

  // Sequencer
  bis_pkg::seq_state_t state;
  bis_pkg::seq_state_t state_next;
  logic [1:0]  chan;
  logic [2:0]  step;
  logic        in_fire;
  logic        rd_issue;
  logic        emit_fire;
  logic        chan_last;

  // Datapath
  logic [CW-1:0]  cx;
  logic [CW-1:0]  cy;
  logic [PW-1:0]  px;
  logic [PW-1:0]  py;
  logic [15:0]    stride;
  logic [16:0]    off_stc;
  logic [XOW-1:0] xoff;
  logic [YOW-1:0] yoff;
  logic [16:0]    wx1;
  logic [16:0]    wx2;
  logic [16:0]    wy1;
  logic [16:0]    wy2;
  logic [WW-1:0]  w11;
  logic [WW-1:0]  w21;
  logic [WW-1:0]  w12;
  logic [WW-1:0]  w22;
  logic [WW-1:0]  wsel;
  logic [16:0]    corner_off;
  logic [1:0]     mem_corner;
  logic [FAW-1:0] chan_addr;
  logic [AW-1:0]  prod;
  logic [AW-1:0]  acc;

  // Frame store ports
  bis_pkg::fs_wr_t fs_wr;
  bis_pkg::fs_rd_t fs_rd;
  logic [7:0]      rd_byte;

  // ---------------------------------------------------------------------------
  // Configuration: writes land at once; all four codes are listed, default is unused.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      source_width <= 13'd1;
      channels     <= 3'd4;
      ratio_x_q16  <= 28'd0;
      ratio_y_q16  <= 28'd0;
    end else if (cfg_write) begin
      case (cfg_index)
        bis_pkg::REG_SOURCE_WIDTH: source_width <= cfg_data[12:0];
        bis_pkg::REG_CHANNELS:     channels     <= cfg_data[2:0];
        bis_pkg::REG_RATIO_X:      ratio_x_q16  <= cfg_data[27:0];
        bis_pkg::REG_RATIO_Y:      ratio_y_q16  <= cfg_data[27:0];
        default: ;
      endcase
    end
  end

  // Clamp channel count: zero acts as one, above the maximum acts as the maximum.
  always_comb begin
    if (channels == 3'd0) begin
      ch_eff = 3'd1;
    end else if (channels > 3'(MAX_CHANNELS)) begin
      ch_eff = 3'(MAX_CHANNELS);
    end else begin
      ch_eff = channels;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  assign chan_last = (3'(chan) + 3'd1) == ch_eff;

  // Outputs of the sequencer
  always_comb begin
    in_ready  = (state == bis_pkg::ST_IDLE);
    rd_issue  = (state == bis_pkg::ST_CHAN) && (step < bis_pkg::READ_STEPS);
    emit_fire = (state == bis_pkg::ST_EMIT) && (!out_valid || out_ready);
  end

  assign in_fire = in_valid && in_ready;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      bis_pkg::ST_IDLE: begin
        if (in_valid && req_type == bis_pkg::REQ_COMPUTE) begin
          state_next = bis_pkg::ST_MUL_POS;
        end
      end
      bis_pkg::ST_MUL_POS: state_next = bis_pkg::ST_MUL_WGT;
      bis_pkg::ST_MUL_WGT: state_next = bis_pkg::ST_BASE;
      bis_pkg::ST_BASE:    state_next = bis_pkg::ST_CHAN;
      bis_pkg::ST_CHAN: begin
        if (step == bis_pkg::CHAN_LAST_STEP) begin
          state_next = bis_pkg::ST_EMIT;
        end
      end
      bis_pkg::ST_EMIT: begin
        if (emit_fire) begin
          state_next = chan_last ? bis_pkg::ST_IDLE : bis_pkg::ST_CHAN;
        end
      end
      default: state_next = bis_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bis_pkg::ST_IDLE;
      chan  <= 2'd0;
      step  <= 3'd0;
    end else begin
      state <= state_next;
      if (state == bis_pkg::ST_BASE) begin
        chan <= 2'd0;
        step <= 3'd0;
      end else if (state == bis_pkg::ST_CHAN) begin
        step <= step + 3'd1;
      end else if (emit_fire) begin
        chan <= chan + 2'd1;
        step <= 3'd0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Setup arithmetic: position, stride, weights, base address.
  // ---------------------------------------------------------------------------
  assign wx2 = {1'b0, px[15:0]};
  assign wy2 = {1'b0, py[15:0]};
  assign wx1 = bis_pkg::ONE_Q16 - wx2;
  assign wy1 = bis_pkg::ONE_Q16 - wy2;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cx <= dest_x[CW-1:0];
      cy <= dest_y[CW-1:0];
    end
    if (state == bis_pkg::ST_MUL_POS) begin
      px     <= PW'(cx) * PW'(ratio_x_q16);
      py     <= PW'(cy) * PW'(ratio_y_q16);
      stride <= 16'(source_width) * 16'(ch_eff);
    end
    if (state == bis_pkg::ST_MUL_WGT) begin
      xoff    <= XOW'(px[PW-1:16]) * XOW'(ch_eff);
      yoff    <= YOW'(py[PW-1:16]) * YOW'(stride);
      off_stc <= 17'(stride) + 17'(ch_eff);
      w11     <= WW'(wx1) * WW'(wy1);
      w21     <= WW'(wx2) * WW'(wy1);
      w12     <= WW'(wx1) * WW'(wy2);
      w22     <= WW'(wx2) * WW'(wy2);
    end
    if (state == bis_pkg::ST_BASE) begin
      chan_addr <= FAW'(xoff) + FAW'(yoff);
    end else if (emit_fire) begin
      chan_addr <= chan_addr + FAW'(1);
    end
  end

  // ---------------------------------------------------------------------------
  // Per channel: issue four corner reads, multiply each byte by its weight,
  // accumulate. Read at step 0..3, data at 1..4, product at 2..5.
  // ---------------------------------------------------------------------------
  always_comb begin
    case (step[1:0])
      2'd0:    corner_off = 17'd0;
      2'd1:    corner_off = 17'(ch_eff);
      2'd2:    corner_off = 17'(stride);
      default: corner_off = off_stc;
    endcase
  end

  assign mem_corner = step[1:0] - 2'd1;

  always_comb begin
    case (mem_corner)
      2'd0:    wsel = w11;
      2'd1:    wsel = w21;
      2'd2:    wsel = w12;
      default: wsel = w22;
    endcase
  end

  always_comb begin
    fs_rd.en   = rd_issue;
    fs_rd.addr = chan_addr + FAW'(corner_off);
    fs_wr.en   = in_fire && (req_type == bis_pkg::REQ_LOAD);
    fs_wr.addr = source_address;
    fs_wr.data = source_value;
  end

  bis_frame_store #(
    .SOURCE_BYTES(SOURCE_BYTES)
  ) u_frame_store (
    .clk     (clk),
    .wr      (fs_wr),
    .rd      (fs_rd),
    .rd_byte (rd_byte)
  );

  always_ff @(posedge clk) begin
    if (state == bis_pkg::ST_CHAN) begin
      prod <= AW'(rd_byte) * AW'(wsel);
      if (step == 3'd2) begin
        acc <= prod;
      end else if (step > 3'd2) begin
        acc <= acc + prod;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: the weighted sum truncated to its top byte.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      pixel_byte    <= acc[AW-1 -: 8];
      channel_index <= chan;
      last_channel  <= chan_last;
    end
  end

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  `BIS_ASSERT_NXT(a_busy_no_accept, in_fire && req_type == bis_pkg::REQ_COMPUTE, !in_ready)
  `BIS_ASSERT_IMP(a_last_matches, out_valid && last_channel, (3'(channel_index) + 3'd1) == ch_eff)
  `BIS_ASSERT_NXT(a_emit_lands, emit_fire, out_valid)
endmodule
`default_nettype wire

[sim/tb_top.sv]
// Self-checking testbench for the bilinear image scaler: directed table, then random phases.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAME_BYTES  = 262144;
  localparam int CHAN_MAX     = 4;
  localparam int IDLE_PCT     = 22;
  // Longest compute runs all four channels; give the block some margin on top.
  localparam int DRAIN_CYCLES = 48;
  localparam int PHASES       = 7;
  localparam int PHASE_BEATS  = 26;

  // One expected output beat: a single interpolated channel.
  typedef struct packed {
    logic [7:0] value;
    logic [1:0] chan;
    logic       last;
  } chan_beat_t;

  typedef enum logic [1:0] {
    ROW_CFG,
    ROW_LOAD,
    ROW_PIXEL
  } row_kind_t;

  // One row of the directed table. Pixel rows may carry the channel bytes
  // typed in (byte k for channel k); otherwise the predictor supplies them.
  typedef struct packed {
    row_kind_t          kind;
    bis_pkg::cfg_reg_t  which;
    logic [27:0]        data;
    logic [17:0]        addr;
    logic [7:0]         value;
    logic [11:0]        dx;
    logic [11:0]        dy;
    logic               typed;
    logic [31:0]        bytes;
  } plan_row_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic        req_type;
  logic [17:0] source_address;
  logic [7:0]  source_value;
  logic [11:0] dest_x;
  logic [11:0] dest_y;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  pixel_byte;
  logic [1:0]  channel_index;
  logic        last_channel;
  logic        cfg_write;
  logic [bis_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [bis_pkg::CFG_DATA_W-1:0]  cfg_data;

  bilinear_image_scaler_top dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .req_type       (req_type),
    .source_address (source_address),
    .source_value   (source_value),
    .dest_x         (dest_x),
    .dest_y         (dest_y),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .pixel_byte     (pixel_byte),
    .channel_index  (channel_index),
    .last_channel   (last_channel),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  // Shadow of the block: frame store, which bytes hold data, and registers.
  logic [7:0]  frame_copy  [FRAME_BYTES];
  bit          frame_known [FRAME_BYTES];
  logic [12:0] width_cfg;
  logic [2:0]  chan_cfg;
  logic [27:0] ratio_x_cfg;
  logic [27:0] ratio_y_cfg;

  // Channel bytes still owed by the block, oldest first.
  chan_beat_t  owed_channels[$];

  bit calm;              // no idling on either side while set
  int mismatches;
  int loads_sent;
  int pixels_sent;
  int beats_checked;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #3_000_000;
    $display("TB_ERROR");
    $finish;
  end

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("[%0t] mismatch on output beat %0d: %s", $time, beats_checked, what);
  endtask

  // Work out where a destination pixel lands in the source: top-left corner
  // address, row stride, effective channel count and the two Q16 fractions.
  function automatic void locate(input logic [11:0] dx, input logic [11:0] dy,
                                 output longint unsigned base,
                                 output longint unsigned stride,
                                 output longint unsigned ch,
                                 output longint unsigned fx,
                                 output longint unsigned fy);
    longint unsigned px;
    longint unsigned py;
    // Clamp the channel register: zero acts as one, above the maximum acts as the maximum.
    ch = (chan_cfg == 3'd0) ? 1 : (chan_cfg > CHAN_MAX) ? CHAN_MAX : chan_cfg;
    px = dx;
    px = px * ratio_x_cfg;
    py = dy;
    py = py * ratio_y_cfg;
    fx = px & 64'hFFFF;
    fy = py & 64'hFFFF;
    stride = ch * width_cfg;
    base = (px >> 16) * ch + (py >> 16) * stride;
  endfunction

  // Corners past the end of the store read as zero.
  function automatic logic [7:0] byte_at(input longint unsigned a);
    return (a < FRAME_BYTES) ? frame_copy[a] : 8'h00;
  endfunction

  // Predict every channel of one destination pixel and queue the bytes.
  function automatic void interpolate_pixel(input logic [11:0] dx, input logic [11:0] dy);
    longint unsigned base, stride, ch, fx, fy;
    longint unsigned wx1, wy1, a11, a12, sum;
    chan_beat_t      b;
    locate(dx, dy, base, stride, ch, fx, fy);
    wx1 = 65536 - fx;
    wy1 = 65536 - fy;
    for (longint unsigned k = 0; k < ch; k++) begin
      a11 = base + k;
      a12 = a11 + stride;
      // The four weights sum to 2^32, so the top byte of the sum is the result.
      sum = byte_at(a11) * (wx1 * wy1) + byte_at(a11 + ch) * (fx * wy1)
          + byte_at(a12) * (wx1 * fy) + byte_at(a12 + ch) * (fx * fy);
      b.value = sum[39:32];
      b.chan  = k[1:0];
      b.last  = (k == ch - 1);
      owed_channels.push_back(b);
    end
  endfunction

  // Drive one input beat and hold it until accepted. Valid is left high on
  // return so that a following beat can go out back to back.
  task automatic send_beat(input bis_pkg::req_kind_t kind, input logic [17:0] addr,
                           input logic [7:0] value, input logic [11:0] dx,
                           input logic [11:0] dy);
    if (!calm)
      while ($urandom_range(99) < IDLE_PCT) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    in_valid       <= 1'b1;
    req_type       <= kind;
    source_address <= addr;
    source_value   <= value;
    dest_x         <= dx;
    dest_y         <= dy;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Loads change the shadow store at issue; nothing after them is sent earlier.
  task automatic send_load(input logic [17:0] addr, input logic [7:0] value);
    frame_copy[addr]  = value;
    frame_known[addr] = 1'b1;
    loads_sent++;
    send_beat(bis_pkg::REQ_LOAD, addr, value, 12'($urandom), 12'($urandom));
  endtask

  // Request one destination pixel. Fill in any corner byte the block would
  // read that has never been written, so no undefined store entry is read.
  task automatic request_pixel(input logic [11:0] dx, input logic [11:0] dy,
                               input logic typed, input logic [31:0] bytes);
    longint unsigned base, stride, ch, fx, fy;
    longint unsigned corner[4];
    chan_beat_t      b;
    locate(dx, dy, base, stride, ch, fx, fy);
    for (longint unsigned k = 0; k < ch; k++) begin
      corner = '{base + k, base + k + ch, base + k + stride, base + k + stride + ch};
      for (int j = 0; j < 4; j++)
        if (corner[j] < FRAME_BYTES && !frame_known[corner[j]])
          send_load(18'(corner[j]), 8'($urandom));
    end
    if (typed) begin
      for (longint unsigned k = 0; k < ch; k++) begin
        b.value = bytes[8*k +: 8];
        b.chan  = k[1:0];
        b.last  = (k == ch - 1);
        owed_channels.push_back(b);
      end
    end else begin
      interpolate_pixel(dx, dy);
    end
    pixels_sent++;
    send_beat(bis_pkg::REQ_COMPUTE, 18'($urandom), 8'($urandom), dx, dy);
  endtask

  // Drop valid, wait for every owed byte, then let any trailing load finish.
  task automatic settle();
    in_valid <= 1'b0;
    while (owed_channels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Registers are only written with the block idle.
  task automatic write_reg(input bis_pkg::cfg_reg_t which, input logic [27:0] data);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= which;
    cfg_data  <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (which)
      bis_pkg::REG_SOURCE_WIDTH: width_cfg   = data[12:0];
      bis_pkg::REG_CHANNELS:     chan_cfg    = data[2:0];
      bis_pkg::REG_RATIO_X:      ratio_x_cfg = data;
      bis_pkg::REG_RATIO_Y:      ratio_y_cfg = data;
      default: ;
    endcase
  endtask

  function automatic logic [27:0] pick_ratio();
    case ($urandom_range(9))
      0: return 28'h0;
      1: return 28'h10000;
      2: return 28'hFFFFFFF;
      default: return 28'($urandom_range(0, 'h2C000));
    endcase
  endfunction

  function automatic plan_row_t cfg_row(input bis_pkg::cfg_reg_t which,
                                        input logic [27:0] data);
    plan_row_t r;
    r = '0;
    r.kind  = ROW_CFG;
    r.which = which;
    r.data  = data;
    return r;
  endfunction

  function automatic plan_row_t load_row(input logic [17:0] addr, input logic [7:0] value);
    plan_row_t r;
    r = '0;
    r.kind  = ROW_LOAD;
    r.addr  = addr;
    r.value = value;
    return r;
  endfunction

  function automatic plan_row_t pixel_row(input logic [11:0] dx, input logic [11:0] dy,
                                          input logic typed, input logic [31:0] bytes);
    plan_row_t r;
    r = '0;
    r.kind  = ROW_PIXEL;
    r.dx    = dx;
    r.dy    = dy;
    r.typed = typed;
    r.bytes = bytes;
    return r;
  endfunction

  // Output side: check each accepted beat against the oldest owed byte, then
  // pick the ready for the next edge.
  always @(posedge clk) begin : sink
    chan_beat_t want;
    if (!rst && out_valid && out_ready) begin
      if (owed_channels.size() == 0) begin
        report_mismatch($sformatf("beat with nothing owed (byte %0d channel %0d)",
                                  pixel_byte, channel_index));
      end else begin
        want = owed_channels.pop_front();
        if (pixel_byte !== want.value)
          report_mismatch($sformatf("pixel_byte %0d, expected %0d", pixel_byte, want.value));
        if (channel_index !== want.chan)
          report_mismatch($sformatf("channel_index %0d, expected %0d",
                                    channel_index, want.chan));
        if (last_channel !== want.last)
          report_mismatch($sformatf("last_channel %0d, expected %0d",
                                    last_channel, want.last));
      end
      beats_checked++;
    end
    out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  initial begin : stimulus
    plan_row_t   plan[$];
    logic [12:0] w;
    logic [2:0]  c;
    logic [27:0] rx, ry, d;
    int          pick;
    int          phase_start;

    width_cfg   = 13'd1;
    chan_cfg    = 3'd4;
    ratio_x_cfg = 28'h0;
    ratio_y_cfg = 28'h0;
    calm        = 1'b0;

    rst            <= 1'b1;
    in_valid       <= 1'b0;
    req_type       <= bis_pkg::REQ_LOAD;
    source_address <= '0;
    source_value   <= '0;
    dest_x         <= '0;
    dest_y         <= '0;
    cfg_write      <= 1'b0;
    cfg_index      <= bis_pkg::REG_SOURCE_WIDTH;
    cfg_data       <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed part: a 2x2 single-channel image at bytes 0..3, then the
    // ratio, width and channel extremes.
    plan.push_back(cfg_row(bis_pkg::REG_CHANNELS, 28'd1));
    plan.push_back(cfg_row(bis_pkg::REG_SOURCE_WIDTH, 28'd2));
    plan.push_back(load_row(18'd0, 8'h5A));
    plan.push_back(load_row(18'd1, 8'hFF));
    plan.push_back(load_row(18'd2, 8'hFF));
    plan.push_back(load_row(18'd3, 8'h00));
    // Ratios still at reset (zero): every pixel is the top-left source byte.
    plan.push_back(pixel_row(12'd0, 12'd0, 1'b1, 32'h5A));
    plan.push_back(pixel_row(12'hFFF, 12'hFFF, 1'b1, 32'h5A));
    plan.push_back(load_row(18'h3FFFF, 8'hA5));
    // Half steps: blends of two and then four corners.
    plan.push_back(cfg_row(bis_pkg::REG_RATIO_X, 28'h8000));
    plan.push_back(pixel_row(12'd1, 12'd0, 1'b0, 32'h0));
    plan.push_back(cfg_row(bis_pkg::REG_RATIO_Y, 28'h8000));
    plan.push_back(pixel_row(12'd1, 12'd1, 1'b0, 32'h0));
    // Zero width: the row below reads row zero again.
    plan.push_back(cfg_row(bis_pkg::REG_SOURCE_WIDTH, 28'd0));
    plan.push_back(pixel_row(12'd1, 12'd1, 1'b0, 32'h0));
    // Channel count zero acts as one.
    plan.push_back(cfg_row(bis_pkg::REG_CHANNELS, 28'd0));
    plan.push_back(pixel_row(12'd0, 12'd0, 1'b0, 32'h0));
    // Channel count seven acts as four; maximum ratios push every corner
    // past the end of the store, so all four channels read zero.
    plan.push_back(cfg_row(bis_pkg::REG_CHANNELS, 28'd7));
    plan.push_back(cfg_row(bis_pkg::REG_SOURCE_WIDTH, 28'h1FFF));
    plan.push_back(cfg_row(bis_pkg::REG_RATIO_X, 28'hFFFFFFF));
    plan.push_back(cfg_row(bis_pkg::REG_RATIO_Y, 28'hFFFFFFF));
    plan.push_back(pixel_row(12'hFFF, 12'hFFF, 1'b1, 32'h0));
    plan.push_back(pixel_row(12'hFFF, 12'd1, 1'b1, 32'h0));

    foreach (plan[i]) begin
      case (plan[i].kind)
        ROW_CFG: begin
          settle();
          write_reg(plan[i].which, plan[i].data);
        end
        ROW_LOAD:
          send_load(plan[i].addr, plan[i].value);
        default:
          request_pixel(plan[i].dx, plan[i].dy, plan[i].typed, plan[i].bytes);
      endcase
    end

    // Random phases. Each starts from an idle block with a fresh setting:
    // first all maxima, then all minima, then random; one phase runs with
    // no idling on either side.
    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      calm = (ph == 2);
      case (ph)
        0: begin
          w  = 13'd4096;
          c  = 3'd4;
          rx = 28'hFFFFFFF;
          ry = 28'hFFFFFFF;
        end
        1: begin
          w  = 13'd1;
          c  = 3'd1;
          rx = 28'h0;
          ry = 28'h0;
        end
        default: begin
          case ($urandom_range(9))
            0:       w = 13'd0;
            1:       w = 13'd4096;
            2:       w = 13'h1FFF;
            default: w = 13'($urandom_range(1, 6));
          endcase
          c  = ($urandom_range(9) < 6) ? 3'($urandom_range(1, 4)) : 3'($urandom_range(0, 7));
          rx = pick_ratio();
          ry = pick_ratio();
        end
      endcase
      // Junk in the bits above each register's width must be dropped.
      d = 28'($urandom);
      d[12:0] = w;
      write_reg(bis_pkg::REG_SOURCE_WIDTH, d);
      d = 28'($urandom);
      d[2:0] = c;
      write_reg(bis_pkg::REG_CHANNELS, d);
      write_reg(bis_pkg::REG_RATIO_X, rx);
      write_reg(bis_pkg::REG_RATIO_Y, ry);

      phase_start = loads_sent + pixels_sent;
      while (loads_sent + pixels_sent - phase_start < PHASE_BEATS) begin
        pick = $urandom_range(99);
        // Mostly pixels near the origin so loaded bytes get reused; some
        // full-range coordinates and some stray loads anywhere in the store.
        if (pick < 15)
          send_load(18'($urandom), 8'($urandom));
        else if (pick < 27)
          request_pixel(12'($urandom), 12'($urandom), 1'b0, 32'h0);
        else
          request_pixel(12'($urandom_range(0, 7)), 12'($urandom_range(0, 7)), 1'b0, 32'h0);
      end
    end
    calm = 1'b0;
    settle();

    $display("run covered %0d loads and %0d pixel requests over %0d random settings",
             loads_sent, pixels_sent, PHASES);
    $display("%0d channel beats checked, %0d mismatches", beats_checked, mismatches);
    if (mismatches == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end
endmodule

[bilinear_image_scaler_top.f]
+incdir+rtl
rtl/bis_pkg.sv
rtl/bis_frame_store.sv
rtl/bilinear_image_scaler_top.sv
sim/tb_top.sv
